@@ src/sts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the script token scanner
// Token codes, scan modes, keyword table and the front-to-back job record.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int unsigned CountBits = 16;
  localparam int unsigned MaxKwLen  = 8;
  localparam int unsigned NumKw     = 21;
  localparam logic [CountBits-1:0] CountMax = '1;

  typedef enum logic [4:0] {
    TOK_END = 5'd0, TOK_PLUS = 5'd1, TOK_MINUS = 5'd2, TOK_COMMENT = 5'd3,
    TOK_MUL = 5'd4, TOK_SLASH = 5'd5, TOK_EXP = 5'd6, TOK_EQ = 5'd7,
    TOK_ASSIGN = 5'd8, TOK_GTE = 5'd9, TOK_GT = 5'd10, TOK_LTE = 5'd11,
    TOK_LT = 5'd12, TOK_LPAREN = 5'd13, TOK_RPAREN = 5'd14, TOK_LBRACKET = 5'd15,
    TOK_RBRACKET = 5'd16, TOK_LBRACE = 5'd17, TOK_RBRACE = 5'd18, TOK_SEMI = 5'd19,
    TOK_DOT = 5'd20, TOK_COMMA = 5'd21, TOK_STRING = 5'd22, TOK_IDENT = 5'd23,
    TOK_KEYWORD = 5'd24, TOK_NUMBER = 5'd25, TOK_INVALID = 5'd26
  } tok_e;

  localparam logic [3:0] MODE_IDLE    = 4'd0;
  localparam logic [3:0] MODE_MINUS   = 4'd1;
  localparam logic [3:0] MODE_ASSIGN  = 4'd2;
  localparam logic [3:0] MODE_GT      = 4'd3;
  localparam logic [3:0] MODE_LT      = 4'd4;
  localparam logic [3:0] MODE_COMMENT = 4'd5;
  localparam logic [3:0] MODE_STRING  = 4'd6;
  localparam logic [3:0] MODE_WORD    = 4'd7;
  localparam logic [3:0] MODE_NUMBER  = 4'd8;

  // One token record.
  typedef struct packed {
    logic [4:0]           ttype;
    logic [4:0]           kw;
    logic [CountBits-1:0] line;
    logic [CountBits-1:0] col;
    logic [CountBits-1:0] len;
  } tok_t;

  // Classified byte handed from front to back: up to two records.
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       t0;
    tok_t       t1;
  } job_t;

  // Keyword text, little byte first, padded with zeros.
  localparam logic [8*MaxKwLen-1:0] KwText [NumKw] = '{
    64'h0000000000646e61, 64'h0000000000646e65, 64'h0000000000006e69,
    64'h0000746165706572, 64'h0000006b61657262, 64'h00000065736c6166,
    64'h0000006c61636f6c, 64'h00006e7275746572, 64'h0000000000006f64,
    64'h0000000000726f66, 64'h00000000006c696e, 64'h000000006e656874,
    64'h0000000065736c65, 64'h6e6f6974636e7566, 64'h0000000000746f6e,
    64'h0000000065757274, 64'h0000666965736c65, 64'h0000000000006669,
    64'h000000000000726f, 64'h0000006c69746e75, 64'h000000656c696877
  };
  localparam logic [3:0] KwLen [NumKw] = '{
    4'd3, 4'd3, 4'd2, 4'd6, 4'd5, 4'd5, 4'd5, 4'd6, 4'd2, 4'd3, 4'd3,
    4'd4, 4'd4, 4'd8, 4'd3, 4'd4, 4'd6, 4'd2, 4'd2, 4'd5, 4'd5
  };

  function automatic logic [CountBits-1:0] sat_add(input logic [CountBits-1:0] a,
                                                   input logic [CountBits-1:0] b);
    logic [CountBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CountBits] ? CountMax : s[CountBits-1:0];
  endfunction

endpackage
`default_nettype wire

@@ src/sts_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sts_front: byte classifier and scan state
// Tracks mode, position and keyword candidates and forms token records.
// ----------------------------------------------------------------------------
module sts_front import sts_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] cfg_data_i,
  input  wire logic       valid_i,
  input  wire logic [7:0] char_byte_i,
  input  wire logic       end_of_input_i,
  output job_t            job_o
);

  logic [3:0]            tab_q, mode_q, mode_d;
  logic [CountBits-1:0]  line_q, line_d, col_q, col_d, tline_q, tline_d;
  logic [CountBits-1:0]  tcol_q, tcol_d, len_q, len_d;
  logic [NumKw-1:0]      cand_q, cand_d;

  // Write the tab width register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_q <= 4'd4;
    end else if (cfg_we_i) begin
      tab_q <= cfg_data_i;
    end
  end

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // Keep candidates whose byte at pos matches.
  function automatic logic [NumKw-1:0] prune_mask(input logic [7:0] c,
                                                  input logic [CountBits-1:0] pos);
    logic [NumKw-1:0] keep;
    keep = '0;
    for (int i = 0; i < NumKw; i++) begin
      if (pos < CountBits'(KwLen[i]) &&
          KwText[i][8*pos[$clog2(MaxKwLen)-1:0] +: 8] == c) begin
        keep[i] = 1'b1;
      end
    end
    return keep;
  endfunction

  tok_t rec0, rec1;
  logic [1:0] cnt;

  always_comb begin
    logic [7:0] c;
    logic eoi, to_idle, closing, adv;
    logic [4:0] single;
    logic [NumKw-1:0] m;
    logic [4:0] kidx;
    logic kfound;
    tok_t pend, idl;
    logic idl_emit;
    c = char_byte_i;
    eoi = end_of_input_i || (c == 8'h00);
    mode_d = mode_q; line_d = line_q; col_d = col_q; tline_d = tline_q;
    tcol_d = tcol_q; len_d = len_q; cand_d = cand_q;
    rec0 = '0; rec1 = '0; cnt = 2'd0;
    to_idle = 1'b0; closing = 1'b0; adv = 1'b1;

    // Record that closes the pending token.
    m = '0;
    for (int i = 0; i < NumKw; i++) begin
      m[i] = cand_q[i] && (CountBits'(KwLen[i]) == len_q);
    end
    kidx = '0; kfound = 1'b0;
    for (int i = NumKw - 1; i >= 0; i--) begin
      if (m[i]) begin kidx = 5'(i); kfound = 1'b1; end
    end
    pend = '0;
    pend.line = tline_q; pend.col = tcol_q; pend.len = len_q;
    case (mode_q)
      MODE_MINUS:   begin pend.ttype = TOK_MINUS;  pend.len = CountBits'(1); end
      MODE_ASSIGN:  begin pend.ttype = TOK_ASSIGN; pend.len = CountBits'(1); end
      MODE_GT:      begin pend.ttype = TOK_GT;     pend.len = CountBits'(1); end
      MODE_LT:      begin pend.ttype = TOK_LT;     pend.len = CountBits'(1); end
      MODE_COMMENT: pend.ttype = TOK_COMMENT;
      MODE_STRING:  pend.ttype = TOK_STRING;
      MODE_NUMBER:  pend.ttype = TOK_NUMBER;
      MODE_WORD:    begin
        pend.ttype = kfound ? TOK_KEYWORD : TOK_IDENT;
        pend.kw = kfound ? kidx : 5'd0;
      end
      default:      pend.ttype = TOK_END;
    endcase

    // Single-byte tokens from idle.
    case (c)
      8'h2b: single = TOK_PLUS;
      8'h2a: single = TOK_MUL;
      8'h2f: single = TOK_SLASH;
      8'h5e: single = TOK_EXP;
      8'h28: single = TOK_LPAREN;
      8'h29: single = TOK_RPAREN;
      8'h5b: single = TOK_LBRACKET;
      8'h5d: single = TOK_RBRACKET;
      8'h7b: single = TOK_LBRACE;
      8'h7d: single = TOK_RBRACE;
      8'h3b: single = TOK_SEMI;
      8'h2e: single = TOK_DOT;
      8'h2c: single = TOK_COMMA;
      default: single = TOK_INVALID;
    endcase

    if (eoi) begin
      adv = 1'b0;
      if (mode_q != MODE_IDLE) begin
        rec0 = pend;
        rec1 = '0; rec1.ttype = TOK_END; rec1.line = line_q; rec1.col = col_q;
        cnt = 2'd2;
      end else begin
        rec0 = '0; rec0.ttype = TOK_END; rec0.line = line_q; rec0.col = col_q;
        cnt = 2'd1;
      end
      mode_d = MODE_IDLE;
    end else begin
      case (mode_q)
        MODE_MINUS: begin
          if (c == 8'h2d) begin mode_d = MODE_COMMENT; len_d = '0; end
          else to_idle = 1'b1;
        end
        MODE_ASSIGN, MODE_GT, MODE_LT: begin
          if (c == 8'h3d) begin
            rec0 = pend; rec0.len = CountBits'(2); cnt = 2'd1;
            rec0.ttype = (mode_q == MODE_ASSIGN) ? TOK_EQ :
                         (mode_q == MODE_GT) ? TOK_GTE : TOK_LTE;
            mode_d = MODE_IDLE;
          end else to_idle = 1'b1;
        end
        MODE_COMMENT: begin
          if (c == 8'h0a) to_idle = 1'b1;
          else len_d = sat_add(len_q, CountBits'(1));
        end
        MODE_STRING: begin
          len_d = sat_add(len_q, CountBits'(1));
          if (c == 8'h22) begin
            rec0 = pend; rec0.len = len_d; cnt = 2'd1; mode_d = MODE_IDLE;
          end
        end
        MODE_WORD: begin
          if (is_letter(c) || c == 8'h5f) begin
            cand_d = cand_q & ((len_q < CountBits'(MaxKwLen)) ?
                               prune_mask(c, len_q) : '0);
            len_d = sat_add(len_q, CountBits'(1));
          end else to_idle = 1'b1;
        end
        MODE_NUMBER: begin
          if (is_digit(c)) len_d = sat_add(len_q, CountBits'(1));
          else to_idle = 1'b1;
        end
        default: begin
          mode_d = MODE_IDLE;
          to_idle = 1'b1;
        end
      endcase
      closing = to_idle && (mode_q != MODE_IDLE);
    end

    // Idle handling of the byte, after any close.
    idl = '0; idl_emit = 1'b0;
    idl.line = line_q; idl.col = col_q; idl.len = CountBits'(1);
    if (to_idle) begin
      mode_d = MODE_IDLE;
      case (c)
        8'h20, 8'h09, 8'h0d, 8'h0a: ;
        8'h2d, 8'h3d, 8'h3e, 8'h3c, 8'h22: begin
          mode_d = (c == 8'h2d) ? MODE_MINUS : (c == 8'h3d) ? MODE_ASSIGN :
                   (c == 8'h3e) ? MODE_GT : (c == 8'h3c) ? MODE_LT : MODE_STRING;
          tline_d = line_q; tcol_d = col_q; len_d = CountBits'(1);
        end
        default: begin
          if (single != TOK_INVALID) begin
            idl.ttype = single; idl_emit = 1'b1;
          end else if (is_letter(c)) begin
            mode_d = MODE_WORD; tline_d = line_q; tcol_d = col_q;
            len_d = CountBits'(1);
            cand_d = prune_mask(c, '0);
          end else if (is_digit(c)) begin
            mode_d = MODE_NUMBER; tline_d = line_q; tcol_d = col_q;
            len_d = CountBits'(1);
          end else begin
            idl.ttype = TOK_INVALID; idl_emit = 1'b1;
          end
        end
      endcase
      if (closing) begin
        rec0 = pend;
        rec1 = idl;
        cnt = idl_emit ? 2'd2 : 2'd1;
      end else if (idl_emit) begin
        rec0 = idl; cnt = 2'd1;
      end
    end

    // Advance position.
    if (adv) begin
      if (c == 8'h0a) begin
        line_d = sat_add(line_q, CountBits'(1)); col_d = CountBits'(1);
      end else if (c == 8'h09) begin
        col_d = sat_add(col_q, CountBits'(tab_q));
      end else begin
        col_d = sat_add(col_q, CountBits'(1));
      end
    end
  end

  // Hold the scan state; advance on each transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE; line_q <= CountBits'(1); col_q <= CountBits'(1);
      tline_q <= CountBits'(1); tcol_q <= CountBits'(1); len_q <= '0; cand_q <= '0;
    end else if (valid_i) begin
      mode_q <= mode_d; line_q <= line_d; col_q <= col_d; tline_q <= tline_d;
      tcol_q <= tcol_d; len_q <= len_d; cand_q <= cand_d;
    end
  end

  assign job_o.cnt = cnt;
  assign job_o.t0  = rec0;
  assign job_o.t1  = rec1;

endmodule
`default_nettype wire

@@ src/sts_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sts_back: job queue and result serializer
// Buffers classified jobs and hands out their records one at a time.
// ----------------------------------------------------------------------------
module sts_back import sts_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  job_t       job_i,
  output logic       full_o,
  output logic       empty_o,
  input  wire logic  pop_i,
  output tok_t       tok_o,
  output logic       last_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned Aw = $clog2(Depth);

  job_t          mem_q [Depth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [Aw:0]   cnt_q;
  logic          sel_q;
  logic          wr, rd;
  job_t          head;

  assign wr      = push_i && !full_o && (job_i.cnt != 2'd0);
  assign full_o  = (cnt_q == (Aw+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head    = mem_q[rp_q];
  assign tok_o   = sel_q ? head.t1 : head.t0;
  assign last_o  = sel_q || (head.cnt == 2'd1);
  assign rd      = pop_i && !empty_o && last_o;

  // Store jobs that carry records.
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= job_i;
  end

  // Advance pointers and the record select.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0; sel_q <= 1'b0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(wr) - (Aw+1)'(rd);
      if (pop_i && !empty_o) sel_q <= !last_o;
    end
  end

endmodule
`default_nettype wire

@@ src/script_token_scanner.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// script_token_scanner: streaming tokenizer top level
// Source bytes in, token records out, both through queue-style handshakes.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive char_byte_i / end_of_input_i with push; a byte is transferred
//   when push is high and full is low. One byte per cycle is taken at full
//   rate while the job queue has room.
//   Output: while empty is low the oldest token is on the result ports; pop
//   transfers it. A byte that yields two tokens shows them on two successive
//   transfers, last_of_run_o marking the second.
//   Queueing: a token enters the job queue with the byte that closes it.
//   Throughput: one byte per cycle; the back end delivers one token per
//   cycle, so a run of two-token bytes is bounded by the four-entry job queue.
//   Stall: when pop stays low the queue fills and full rises; nothing is lost.
//   Reset: line, column at 1, scanner idle, queue empty, tab width 4. The user
//   writes tab_width via cfg_we_i / cfg_data_i only while idle; not enforced.
// ----------------------------------------------------------------------------
module script_token_scanner import sts_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_data_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  char_byte_i,
  input  wire logic        end_of_input_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [4:0]       token_type_o,
  output logic [4:0]       keyword_index_o,
  output logic [15:0]      start_line_o,
  output logic [15:0]      start_column_o,
  output logic [15:0]      token_length_o,
  output logic             last_of_run_o
);

  job_t job;
  tok_t tok;

  sts_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .valid_i(push && !full), .char_byte_i, .end_of_input_i, .job_o(job)
  );

  sts_back u_back (
    .clk_i, .rst_ni, .push_i(push), .job_i(job), .full_o(full),
    .empty_o(empty), .pop_i(pop), .tok_o(tok), .last_o(last_of_run_o)
  );

  assign token_type_o    = tok.ttype;
  assign keyword_index_o = tok.kw;
  assign start_line_o    = tok.line[15:0];
  assign start_column_o  = tok.col[15:0];
  assign token_length_o  = tok.len[15:0];

endmodule
`default_nettype wire

@@ src/sts_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sts_checker: port-level checks of the token scanner
// Watches the result channel and attaches to the top level by bind.
// ----------------------------------------------------------------------------
module sts_checker import sts_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [4:0]  token_type_o,
  input wire logic [4:0]  keyword_index_o,
  input wire logic [15:0] start_line_o,
  input wire logic        last_of_run_o
);

  // Only keyword tokens carry a keyword index.
  a_kw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && token_type_o != TOK_KEYWORD |-> keyword_index_o == 5'd0)
    else $error("keyword index on non-keyword token");

  // Token codes stay in range.
  a_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> token_type_o <= TOK_INVALID)
    else $error("token type out of range");

  // A held result does not change.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(token_type_o) && $stable(start_line_o))
    else $error("result changed while stalled");

  // The end token always closes a run.
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && token_type_o == TOK_END |-> last_of_run_o)
    else $error("end token not last of run");

endmodule

bind script_token_scanner sts_checker u_sts_checker (
  .clk_i, .rst_ni, .empty, .pop, .token_type_o, .keyword_index_o,
  .start_line_o, .last_of_run_o
);
`default_nettype wire
